/* rtl/ascii_frame_receiver_checksum_assert.svh */
// Assertion macros for the ASCII frame receiver.
`ifndef ASCII_FRAME_RECEIVER_CHECKSUM_ASSERT_SVH
`define ASCII_FRAME_RECEIVER_CHECKSUM_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define AFRC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define AFRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/afrc_pkg.sv */
// Shared types and constants for the ASCII frame receiver.
package afrc_pkg;

  localparam int unsigned BUFFER_SIZE_DEF = 120;
  localparam int unsigned MIN_FRAME       = 7;

  localparam logic [9:0] TIMEOUT_RST = 10'd20;

  // event kinds
  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_DRV_ERR = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_REPLY   = 3'd1;
  localparam logic [2:0] ST_DRV_ERROR  = 3'd2;
  localparam logic [2:0] ST_TOO_MUCH   = 3'd3;
  localparam logic [2:0] ST_NOT_ENOUGH = 3'd4;
  localparam logic [2:0] ST_CHECKSUM   = 3'd5;

  localparam logic [7:0] PRINT_MIN  = 8'h20;
  localparam logic [7:0] CHK_MASK   = 8'h3F;
  localparam logic [7:0] CHK_OFFSET = 8'h20;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t data;
  } in_slot_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] status;
    logic [6:0] frame_length;
  } res_t;

endpackage

/* rtl/afrc_in_stage.sv */
// Input register stage: holds one event until the core consumes it.
module afrc_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_valid,
  output logic               s_ready,
  input  afrc_pkg::item_t    s_item,
  input  logic               take,
  output afrc_pkg::in_slot_t slot
);
  import afrc_pkg::*;

  logic  slot_valid;
  item_t slot_item;

  assign s_ready = !slot_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (s_ready) begin
      slot_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      slot_item <= s_item;
    end
  end

  assign slot = '{valid: slot_valid, data: slot_item};

endmodule

/* rtl/afrc_frame_core.sv */
// Frame state and combinational judgment of each event.
module afrc_frame_core #(
  parameter int unsigned BUFFER_SIZE = afrc_pkg::BUFFER_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [9:0]         cfg_wr_data,
  input  afrc_pkg::in_slot_t slot,
  input  logic               out_free,
  output logic               take,
  output afrc_pkg::res_t     res
);
  import afrc_pkg::*;

  localparam int unsigned CW = $clog2(BUFFER_SIZE);
  localparam logic [CW:0] FULL_COUNT = (CW + 1)'(BUFFER_SIZE - 1);
  localparam logic [CW:0] MIN_COUNT  = (CW + 1)'(MIN_FRAME);

  logic [9:0]    timeout_ticks;
  logic [CW-1:0] byte_count;
  logic [7:0]    running_sum;
  logic [7:0]    latest_byte;
  logic [9:0]    idle_count;

  logic [CW:0]   cnt_inc;
  logic [CW:0]   len_src;
  logic [CW+7:0] len_ext;
  logic [9:0]    idle_inc;
  logic [7:0]    others;
  logic [7:0]    expect_byte;
  logic          fire;
  logic          load_byte;
  logic          bump_idle;
  logic [2:0]    status;

  assign cnt_inc     = {1'b0, byte_count} + (CW + 1)'(1);
  assign idle_inc    = idle_count + 10'd1;
  assign others      = running_sum - latest_byte;
  assign expect_byte = (others & CHK_MASK) + CHK_OFFSET;

  always_comb begin
    fire      = 1'b0;
    load_byte = 1'b0;
    bump_idle = 1'b0;
    status    = ST_OK;
    case (slot.data.cmd)
      CMD_TICK: begin
        if (idle_inc >= timeout_ticks || idle_inc == 10'd0) begin
          fire   = 1'b1;
          status = ST_NO_REPLY;
        end else begin
          bump_idle = 1'b1;
        end
      end
      CMD_DRV_ERR: begin
        fire   = 1'b1;
        status = ST_DRV_ERROR;
      end
      CMD_BYTE: begin
        if (slot.data.rx_byte < PRINT_MIN) begin
          // control byte closes the frame
          fire = 1'b1;
          if (byte_count == '0) begin
            status = ST_NO_REPLY;
          end else if ({1'b0, byte_count} < MIN_COUNT) begin
            status = ST_NOT_ENOUGH;
          end else if (expect_byte != latest_byte) begin
            status = ST_CHECKSUM;
          end else begin
            status = ST_OK;
          end
        end else begin
          load_byte = 1'b1;
          if (cnt_inc >= FULL_COUNT) begin
            fire   = 1'b1;
            status = ST_TOO_MUCH;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // buffer-full reports the count including the byte just taken
  assign len_src = load_byte ? cnt_inc : {1'b0, byte_count};
  assign len_ext = {7'd0, len_src};

  assign take = slot.valid && (!fire || out_free);

  assign res = '{valid: take && fire, status: status, frame_length: len_ext[6:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      timeout_ticks <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_sum <= '0;
      latest_byte <= '0;
      idle_count  <= '0;
    end else if (take) begin
      if (fire) begin
        byte_count  <= '0;
        running_sum <= '0;
        latest_byte <= '0;
        idle_count  <= '0;
      end else if (load_byte) begin
        byte_count  <= cnt_inc[CW-1:0];
        running_sum <= running_sum + slot.data.rx_byte;
        latest_byte <= slot.data.rx_byte;
        idle_count  <= '0;
      end else if (bump_idle) begin
        idle_count <= idle_inc;
      end
    end
  end

endmodule

/* rtl/afrc_out_stage.sv */
// Result register toward the output stream.
module afrc_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  afrc_pkg::res_t res,
  output logic           out_free,
  output logic           m_valid,
  input  logic           m_ready,
  output logic [2:0]     status,
  output logic [6:0]     frame_length
);
  import afrc_pkg::*;

  assign out_free = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (out_free) begin
      m_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      status       <= res.status;
      frame_length <= res.frame_length;
    end
  end

endmodule

/* rtl/ascii_frame_receiver_checksum.sv */
// Top level of the ASCII frame receiver with 6-bit sum checksum.
//
// Takes one event per beat (received byte, idle tick or driver error) and
// gives at most one result beat per finished frame: a status code and the
// count of printable bytes in the frame. Printable bytes (0x20 and up) add
// to a mod-256 sum; a control byte closes the frame, which passes when its
// last byte equals ((sum of the other bytes) & 0x3F) + 0x20 and it holds at
// least 7 bytes. Idle ticks reaching timeout_ticks report no-reply, a driver
// error aborts, and BUFFER_SIZE-1 bytes report too-much-data. Every result
// starts a new frame. Rate: one event per clock, sustained. An event is
// held in the input register and judged there by the combinational frame
// core, and its result is then registered in the result register. A
// stalled result only holds back events that would produce another result.
// timeout_ticks is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while the block is idle, which the block does not enforce.
`include "ascii_frame_receiver_checksum_assert.svh"

module ascii_frame_receiver_checksum #(
  parameter int unsigned BUFFER_SIZE = afrc_pkg::BUFFER_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // config: timeout_ticks
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,
  // event stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [2:0] status, [9:3] frame_length, rest zero
);
  import afrc_pkg::*;

  item_t      s_item;
  in_slot_t   slot;
  res_t       res;
  logic       take;
  logic       out_free;
  logic [2:0] status;
  logic [6:0] frame_length;

  assign s_item = '{cmd: s_axis_tuser, rx_byte: s_axis_tdata};

  // event register
  afrc_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_item  (s_item),
    .take    (take),
    .slot    (slot)
  );

  // frame state and judgment
  afrc_frame_core #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .slot        (slot),
    .out_free    (out_free),
    .take        (take),
    .res         (res)
  );

  // result register
  afrc_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .out_free     (out_free),
    .m_valid      (m_axis_tvalid),
    .m_ready      (m_axis_tready),
    .status       (status),
    .frame_length (frame_length)
  );

  assign m_axis_tdata = {6'd0, frame_length, status};

  // a result is only produced into a free result register
  `AFRC_ASSERT_SAME(a_res_into_free, res.valid, out_free, "result produced while output busy")
  // a held event is not dropped
  `AFRC_ASSERT_NEXT(a_slot_held, slot.valid && !take, slot.valid, "held event lost")
  // an empty event register always takes a beat
  `AFRC_ASSERT_SAME(a_ready_empty, !slot.valid, s_axis_tready, "empty stage not ready")

endmodule

/* sim/ascii_frame_receiver_checksum_checker.sv */
// Checker for the ASCII frame receiver: frame result prediction and result comparison.
`timescale 1ns / 1ps

module ascii_frame_receiver_checksum_checker #(
  parameter int unsigned BUFFER_SIZE = afrc_pkg::BUFFER_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [2:0] status, [9:3] frame_length, rest zero
  output int          mismatches,
  output int          pending
);
  import afrc_pkg::*;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] frame_length;
  } frame_result_t;

  // frame state
  logic [9:0]    timeout_ticks;
  int unsigned   byte_count;
  logic [7:0]    char_sum;
  logic [7:0]    last_char;
  logic [9:0]    idle_ticks;

  frame_result_t expected_frames[$];
  int            mismatch_cnt = 0;

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    mismatch_cnt++;
  endtask

  function automatic void close_frame(input logic [2:0] st);
    frame_result_t r;
    r.status       = st;
    r.frame_length = byte_count[6:0];
    expected_frames.push_back(r);
    byte_count = 0;
    char_sum   = '0;
    last_char  = '0;
    idle_ticks = '0;
  endfunction

  function automatic void judge_event(input logic [1:0] c, input logic [7:0] b);
    logic [7:0] others;
    logic [7:0] want;
    case (c)
      CMD_TICK: begin
        idle_ticks = idle_ticks + 10'd1;
        if (idle_ticks >= timeout_ticks || idle_ticks == '0)
          close_frame(ST_NO_REPLY);
      end
      CMD_DRV_ERR: close_frame(ST_DRV_ERROR);
      CMD_BYTE: begin
        if (b < PRINT_MIN) begin
          if (byte_count == 0) begin
            close_frame(ST_NO_REPLY);
          end else if (byte_count < MIN_FRAME) begin
            close_frame(ST_NOT_ENOUGH);
          end else begin
            // checksum char covers every byte but itself
            others = char_sum - last_char;
            want   = (others & CHK_MASK) + CHK_OFFSET;
            close_frame((want == last_char) ? ST_OK : ST_CHECKSUM);
          end
        end else begin
          idle_ticks = '0;
          last_char  = b;
          char_sum   = char_sum + b;
          byte_count++;
          if (byte_count >= BUFFER_SIZE - 1)
            close_frame(ST_TOO_MUCH);
        end
      end
      default: ;  // unused command, dropped
    endcase
  endfunction

  always @(posedge clk) begin
    frame_result_t exp_res;
    if (rst) begin
      timeout_ticks = TIMEOUT_RST;
      byte_count    = 0;
      char_sum      = '0;
      last_char     = '0;
      idle_ticks    = '0;
      expected_frames.delete();
    end else begin
      if (cfg_wr_en)
        timeout_ticks = cfg_wr_data;
      // result beats trail their events, so retire before predicting
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("unexpected result beat", -1, m_axis_tdata);
        end else begin
          exp_res = expected_frames.pop_front();
          if (m_axis_tdata[2:0] !== exp_res.status)
            report_mismatch("status", exp_res.status, m_axis_tdata[2:0]);
          if (m_axis_tdata[9:3] !== exp_res.frame_length)
            report_mismatch("frame_length", exp_res.frame_length, m_axis_tdata[9:3]);
          if (m_axis_tdata[15:10] !== 6'd0)
            report_mismatch("tdata padding", 0, m_axis_tdata[15:10]);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        judge_event(s_axis_tuser, s_axis_tdata);
    end
    mismatches <= mismatch_cnt;
    pending    <= expected_frames.size();
  end

endmodule

/* sim/ascii_frame_receiver_checksum_tb.sv */
// Testbench top for the ASCII frame receiver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module ascii_frame_receiver_checksum_tb;
  import afrc_pkg::*;

  localparam int         WATCHDOG_LIMIT = 5000;  // quiet cycles before giving up
  localparam int         DRAIN_CYCLES   = 8;     // pipeline: event register, then result register
  localparam int         HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam logic [1:0] CMD_UNUSED     = 2'd3;  // dropped by the block
  localparam logic [7:0] CH_CR          = 8'h0D;
  localparam logic [7:0] CH_LF          = 8'h0A;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [9:0]  cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic [1:0]  s_axis_tuser;   // [1:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [2:0] status, [9:3] frame_length, rest zero

  int          mismatches;
  int          pending;

  // stimulus bookkeeping
  int          events_sent = 0;  // counted beats, unused commands excluded
  logic [9:0]  cur_timeout = TIMEOUT_RST;
  bit          idle_on     = 1'b1;  // random bursts on both sides
  bit          hold_go     = 1'b0;  // asks the receiver for one long hold-off
  int          quiet_cycles = 0;

  ascii_frame_receiver_checksum dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ascii_frame_receiver_checksum_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one event beat; valid stays high after the handshake so back-to-back
  // beats never see valid dropped and raised in the same step.
  task automatic send_event(input logic [1:0] c, input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (c != CMD_UNUSED)
      events_sent++;
  endtask

  function automatic logic [7:0] printable_char();
    return 8'($urandom_range(32, 255));
  endfunction

  function automatic logic [7:0] control_char();
    return 8'($urandom_range(0, 31));
  endfunction

  // A reply line: body chars, then the checksum char, then a control char.
  // A bad frame gets a checksum char that differs in its low six bits.
  // Noise slips ticks and unused commands between the chars.
  task automatic send_frame(input int n_chars, input bit good, input bit noisy);
    logic [7:0] sum8;
    logic [7:0] chk;
    logic [7:0] c;
    sum8 = '0;
    for (int i = 0; i < n_chars - 1; i++) begin
      c = printable_char();
      sum8 = sum8 + c;
      send_event(CMD_BYTE, c);
      if (noisy && $urandom_range(0, 4) == 0)
        send_event($urandom_range(0, 1) ? CMD_UNUSED : CMD_TICK, 8'($urandom));
    end
    chk = (sum8 & CHK_MASK) + CHK_OFFSET;
    if (!good)
      chk = (((sum8 & CHK_MASK) ^ 8'($urandom_range(1, 63))) & CHK_MASK) + CHK_OFFSET;
    send_event(CMD_BYTE, chk);
    send_event(CMD_BYTE, control_char());
  endtask

  // Long line: hits the buffer limit when it reaches BUFFER_SIZE-1 chars.
  task automatic send_long_line(input int n_chars);
    repeat (n_chars) send_event(CMD_BYTE, printable_char());
    send_event(CMD_BYTE, CH_LF);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_event(CMD_TICK, 8'($urandom));
  endtask

  // Let every expected result out, then give the pipeline time to settle.
  // pending is updated with nonblocking writes, so it is a registered copy.
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [9:0] ticks);
    wait_all_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ticks;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_timeout = ticks;
  endtask

  // Mostly well-formed lines with random content, plus short, empty, broken,
  // aborted, long and timed-out lines and raw noise.
  task automatic random_traffic(input int upto);
    int kind;
    int n;
    while (events_sent < upto) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        send_frame($urandom_range(7, 14), 1'b1, $urandom_range(0, 3) == 0);
      end else if (kind < 60) begin
        send_frame($urandom_range(7, 14), 1'b0, 1'b0);
      end else if (kind < 68) begin
        send_frame($urandom_range(1, 6), $urandom_range(0, 1), 1'b0);
      end else if (kind < 72) begin
        send_event(CMD_BYTE, control_char());          // empty line
      end else if (kind < 80) begin
        // tick run that just reaches (or misses by one) a timeout up to 40, else a short run
        n = (cur_timeout <= 40) ? cur_timeout - $urandom_range(0, 1) : $urandom_range(1, 8);
        if (n < 1)
          n = 1;
        if ($urandom_range(0, 1))
          repeat ($urandom_range(1, 5)) send_event(CMD_BYTE, printable_char());
        send_ticks(n);
      end else if (kind < 86) begin
        repeat ($urandom_range(0, 10)) send_event(CMD_BYTE, printable_char());
        send_event(CMD_DRV_ERR, 8'($urandom));
      end else if (kind < 92) begin
        repeat ($urandom_range(1, 4)) send_event(2'($urandom_range(0, 3)), 8'($urandom));
      end else if (kind < 94) begin
        send_long_line($urandom_range(110, 125));
      end else begin
        send_frame($urandom_range(7, 20), 1'b1, 1'b1);
      end
    end
  endtask

  // Receiver: random stall bursts, and one long hold-off on request so the
  // block backs up and stalls its event input.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  initial begin
    forever begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_BYTE;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed lines at the reset timeout of 20 ticks.
    send_event(CMD_BYTE, CH_CR);                  // empty line: no reply
    send_event(CMD_BYTE, 8'h41);                  // 3 chars: not enough data
    send_event(CMD_BYTE, 8'h42);
    send_event(CMD_BYTE, 8'h43);
    send_event(CMD_BYTE, CH_LF);
    send_frame(7, 1'b1, 1'b0);                    // shortest good line
    repeat (6) send_event(CMD_BYTE, 8'hFF);       // all-ones body, wrong checksum
    send_event(CMD_BYTE, 8'h20);
    send_event(CMD_BYTE, 8'h00);
    send_event(CMD_BYTE, 8'h20);                  // lowest printable
    send_event(CMD_BYTE, 8'h7F);
    send_event(CMD_UNUSED, 8'hA5);                // dropped, no result
    send_event(CMD_TICK, 8'h00);                  // below timeout
    send_event(CMD_DRV_ERR, 8'hFF);               // abort with 2 chars held
    send_event(CMD_BYTE, 8'h1F);                  // highest control: empty line

    // Reset timeout, with the long receiver hold-off at the start.
    hold_go = 1'b1;
    random_traffic(200);

    write_timeout(10'd1);
    random_traffic(380);

    write_timeout(10'd0);                         // times out on the first tick
    random_traffic(530);

    // Largest timeout: tick runs well short of it and a line that fills the buffer.
    write_timeout(10'd1023);
    send_ticks(40);
    send_event(CMD_BYTE, printable_char());       // restarts the idle count
    send_ticks(20);
    send_long_line(BUFFER_SIZE_DEF + 2);
    random_traffic(events_sent + 130);

    write_timeout(10'($urandom_range(2, 40)));
    random_traffic(events_sent + 130);

    // Last part at full rate on both sides.
    write_timeout(TIMEOUT_RST);
    idle_on = 1'b0;
    random_traffic(events_sent + 130);

    wait_all_results();
    if (mismatches == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/afrc_pkg.sv
rtl/afrc_in_stage.sv
rtl/afrc_frame_core.sv
rtl/afrc_out_stage.sv
rtl/ascii_frame_receiver_checksum.sv
sim/ascii_frame_receiver_checksum_checker.sv
sim/ascii_frame_receiver_checksum_tb.sv
